FILE: rtl/core/mnps_pkg.sv
package mnps_pkg;

  localparam int ID_W   = 31;
  localparam int LAT_W  = 25;
  localparam int LON_W  = 26;
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int DIST_W = LON_W + 1;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } entry_t;

  // query start from the control fsm to the scan unit
  typedef struct packed {
    logic                    start;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } scan_ctl_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] best_id;
  } scan_stat_t;

endpackage

FILE: rtl/core/mnps_if.sv
interface mnps_in_if import mnps_pkg::*;;
  logic                    valid;
  logic                    ready;
  cmd_t                    cmd;
  logic [ID_W-1:0]         entry_id;
  logic signed [LAT_W-1:0] coord_lat;
  logic signed [LON_W-1:0] coord_lon;

  modport source (output valid, cmd, entry_id, coord_lat, coord_lon, input ready);
  modport sink (input valid, cmd, entry_id, coord_lat, coord_lon, output ready);
endinterface

interface mnps_out_if import mnps_pkg::*;;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] nearest_id;
  logic            table_empty;

  modport source (output valid, nearest_id, table_empty, input ready);
  modport sink (input valid, nearest_id, table_empty, output ready);
endinterface

FILE: rtl/core/mnps_point_mem.sv
module mnps_point_mem import mnps_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mnps_scan.sv
module mnps_scan import mnps_pkg::*; #(
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_ctl_t     ctl,
  input  logic [CW-1:0] count,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output scan_stat_t    stat
);

  logic                     active_r;
  logic [CW-1:0]            addr_r;
  logic [CW-1:0]            addr_nxt;
  logic                     last_issue;
  logic                     rdv_r;
  logic                     rdl_r;
  logic                     dv2_r;
  logic                     last2_r;
  logic                     first_r;
  logic                     done_r;
  logic signed [LAT_W-1:0]  q_lat_r;
  logic signed [LON_W-1:0]  q_lon_r;
  logic signed [DLAT_W-1:0] dlat;
  logic signed [DLON_W-1:0] dlon;
  logic [DLAT_W-1:0]        alat;
  logic [DLON_W-1:0]        alon;
  logic [DIST_W-1:0]        cur_dist;
  logic [DIST_W-1:0]        dist_r;
  logic [ID_W-1:0]          id2_r;
  logic [DIST_W-1:0]        best_d_r;
  logic [ID_W-1:0]          best_id_r;

  assign addr_nxt   = addr_r + 1'b1;
  assign last_issue = active_r && (addr_nxt == count);
  assign rd_en      = active_r;
  assign rd_addr    = addr_r[AW-1:0];

  // distance of the entry that the memory just returned
  always_comb begin
    dlat     = DLAT_W'(q_lat_r) - DLAT_W'(rd_data.lat);
    dlon     = DLON_W'(q_lon_r) - DLON_W'(rd_data.lon);
    alat     = dlat[DLAT_W-1] ? DLAT_W'(-dlat) : DLAT_W'(dlat);
    alon     = dlon[DLON_W-1] ? DLON_W'(-dlon) : DLON_W'(dlon);
    cur_dist = DIST_W'(alat[DLAT_W-2:0]) + DIST_W'(alon[DLON_W-2:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      addr_r   <= '0;
      rdv_r    <= 1'b0;
      rdl_r    <= 1'b0;
      dv2_r    <= 1'b0;
      last2_r  <= 1'b0;
      first_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (ctl.start) begin
        active_r <= 1'b1;
        addr_r   <= '0;
        first_r  <= 1'b1;
      end else if (active_r) begin
        addr_r <= addr_nxt;
        if (last_issue) begin
          active_r <= 1'b0;
        end
      end
      rdv_r   <= active_r;
      rdl_r   <= last_issue;
      dv2_r   <= rdv_r;
      last2_r <= rdl_r;
      done_r  <= dv2_r && last2_r;
      if (dv2_r) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_lat_r <= ctl.lat;
      q_lon_r <= ctl.lon;
    end
    if (rdv_r) begin
      dist_r <= cur_dist;
      id2_r  <= rd_data.id;
    end
    // strict compare keeps the earliest entry on a tie
    if (dv2_r && (first_r || (dist_r < best_d_r))) begin
      best_d_r  <= dist_r;
      best_id_r <= id2_r;
    end
  end

  assign stat.done    = done_r;
  assign stat.best_id = best_id_r;

endmodule

FILE: rtl/core/manhattan_nearest_point_search.sv
// Nearest stored point by Manhattan distance. Load transfers append a point
// (id, latitude, longitude) to an on-chip table of MAX_POINTS entries and are
// dropped once the table is full; a clear transfer empties the table; neither
// gives a result. A query transfer scans the stored points in load order
// through the single read port of the point memory, one entry per cycle, and
// returns the id with the smallest |dlat|+|dlon|, the earliest point winning
// a tie. A query on an empty table reports table_empty with nearest_id 0.
// Loads and clears are taken while an earlier result still waits on the
// output register.
module manhattan_nearest_point_search import mnps_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mnps_in_if.sink     in_chan,
  mnps_out_if.source  out_chan
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]      state_r;
  logic [CW-1:0]   count_r;
  logic            in_xfer;
  logic            mem_we;
  entry_t          mem_wdata;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;
  scan_ctl_t       scan_ctl;
  scan_stat_t      scan_stat;
  logic [ID_W-1:0] res_id_r;
  logic            res_empty_r;
  logic            out_valid_r;
  logic [ID_W-1:0] out_id_r;
  logic            out_empty_r;
  logic            out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign mem_we        = in_xfer && (in_chan.cmd == CMD_LOAD) && (count_r < CW'(MAX_POINTS));
  assign mem_wdata.id  = in_chan.entry_id;
  assign mem_wdata.lat = in_chan.coord_lat;
  assign mem_wdata.lon = in_chan.coord_lon;

  assign scan_ctl.start = in_xfer && (in_chan.cmd == CMD_QUERY) && (count_r != '0);
  assign scan_ctl.lat   = in_chan.coord_lat;
  assign scan_ctl.lon   = in_chan.coord_lon;

  mnps_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mnps_scan #(
    .CW (CW),
    .AW (AW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .count   (count_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_chan.cmd)
              CMD_CLEAR: count_r <= '0;
              CMD_LOAD: begin
                if (mem_we) begin
                  count_r <= count_r + 1'b1;
                end
              end
              CMD_QUERY: begin
                state_r <= (count_r == '0) ? ST_FINISH : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_stat.done) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_chan.cmd == CMD_QUERY) && (count_r == '0)) begin
      res_id_r    <= '0;
      res_empty_r <= 1'b1;
    end else if ((state_r == ST_SCAN) && scan_stat.done) begin
      res_id_r    <= scan_stat.best_id;
      res_empty_r <= 1'b0;
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_id_r    <= res_id_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.nearest_id  = out_id_r;
  assign out_chan.table_empty = out_empty_r;

endmodule

FILE: tb/nearest_point_checker.sv
module nearest_point_checker import mnps_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mnps_in_if          in_mon,
  mnps_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned awaiting
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] nearest_id;
    logic            table_empty;
  } nearest_t;

  logic [ID_W-1:0]         tab_id  [MAX_POINTS];
  logic signed [LAT_W-1:0] tab_lat [MAX_POINTS];
  logic signed [LON_W-1:0] tab_lon [MAX_POINTS];
  int unsigned             point_count;
  nearest_t                answers [$];

  function automatic longint span(input longint a, input longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  // scan in load order, strict less-than keeps the earliest point on a tie
  function automatic nearest_t find_nearest(input logic signed [LAT_W-1:0] qlat,
                                            input logic signed [LON_W-1:0] qlon);
    nearest_t res;
    longint   best_d;
    longint   d;
    res    = '{nearest_id: '0, table_empty: 1'b1};
    best_d = 0;
    for (int i = 0; i < int'(point_count); i++) begin
      d = span(longint'(qlat), longint'(tab_lat[i])) + span(longint'(qlon), longint'(tab_lon[i]));
      if (i == 0 || d < best_d) begin
        best_d          = d;
        res.nearest_id  = tab_id[i];
        res.table_empty = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    nearest_t want;
    if (!rst_n) begin
      point_count = 0;
      mismatches  = 0;
      answers.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual nearest_id %0d table_empty %0b",
                   $time, out_mon.nearest_id, out_mon.table_empty);
          mismatches++;
        end else begin
          want = answers.pop_front();
          if (out_mon.nearest_id !== want.nearest_id) begin
            $display("%0t: nearest_id mismatch: expected %0d actual %0d",
                     $time, want.nearest_id, out_mon.nearest_id);
            mismatches++;
          end
          if (out_mon.table_empty !== want.table_empty) begin
            $display("%0t: table_empty mismatch: expected %0b actual %0b",
                     $time, want.table_empty, out_mon.table_empty);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_CLEAR: point_count = 0;
          CMD_LOAD: begin
            // loads into a full table are dropped
            if (point_count < MAX_POINTS) begin
              tab_id[point_count]  = in_mon.entry_id;
              tab_lat[point_count] = in_mon.coord_lat;
              tab_lon[point_count] = in_mon.coord_lon;
              point_count++;
            end
          end
          CMD_QUERY: answers.push_back(find_nearest(in_mon.coord_lat, in_mon.coord_lon));
          default: ;
        endcase
      end
    end
    awaiting <= answers.size();
  end

endmodule

FILE: tb/tb_manhattan_nearest_point_search.sv
module tb_manhattan_nearest_point_search;

  timeunit 1ns;
  timeprecision 1ps;

  import mnps_pkg::*;

  localparam int   MAX_POINTS     = 1024;
  localparam int   LONG_HOLD      = 200;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam cmd_t CMD_UNUSED     = 2'd3;

  localparam logic signed [LAT_W-1:0] LAT_TOP = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic signed [LAT_W-1:0] LAT_BOT = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_TOP = {1'b0, {(LON_W-1){1'b1}}};
  localparam logic signed [LON_W-1:0] LON_BOT = {1'b1, {(LON_W-1){1'b0}}};
  localparam logic [ID_W-1:0]         ID_TOP  = '1;

  typedef enum int {SPREAD_CLUSTER, SPREAD_WIDE, SPREAD_RAW} spread_e;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned gap_pct;
  bit          stall_req;
  bit          stall_taken;
  bit          quiet;

  mnps_in_if  in_chan ();
  mnps_out_if out_chan ();

  manhattan_nearest_point_search #(.MAX_POINTS(MAX_POINTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  nearest_point_checker #(.MAX_POINTS(MAX_POINTS)) nearest_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [ID_W-1:0] pick_id();
    // a small pool makes repeated ids likely
    if ($urandom_range(0, 4) == 0) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom());
  endfunction

  function automatic logic signed [LAT_W-1:0] pick_lat(input spread_e s);
    int v;
    case (s)
      SPREAD_CLUSTER: v = int'($urandom_range(0, 16)) - 8;
      SPREAD_WIDE:    v = int'($urandom_range(0, 18000000)) - 9000000;
      default:        v = int'($urandom());
    endcase
    return LAT_W'(v);
  endfunction

  function automatic logic signed [LON_W-1:0] pick_lon(input spread_e s);
    int v;
    case (s)
      SPREAD_CLUSTER: v = int'($urandom_range(0, 16)) - 8;
      SPREAD_WIDE:    v = int'($urandom_range(0, 36000000)) - 18000000;
      default:        v = int'($urandom());
    endcase
    return LON_W'(v);
  endfunction

  task automatic issue(input cmd_t c, input logic [ID_W-1:0] id,
                       input logic signed [LAT_W-1:0] la, input logic signed [LON_W-1:0] lo);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= c;
    in_chan.entry_id  <= id;
    in_chan.coord_lat <= la;
    in_chan.coord_lon <= lo;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_for_answers();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // tables built from clear, loads and queries in random order
  task automatic run_random_sets(input int unsigned target);
    int unsigned             sent;
    int unsigned             n_pts;
    int unsigned             n_q;
    int unsigned             k;
    int unsigned             j;
    spread_e                 s;
    logic signed [LAT_W-1:0] la;
    logic signed [LON_W-1:0] lo;
    logic signed [LAT_W-1:0] lat_seen [$];
    logic signed [LON_W-1:0] lon_seen [$];
    sent = 0;
    while (sent < target) begin
      k = $urandom_range(0, 9);
      s = (k < 3) ? SPREAD_CLUSTER : (k < 8) ? SPREAD_WIDE : SPREAD_RAW;
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 16);
      n_q   = $urandom_range(1, 5);
      if ($urandom_range(0, 4) != 0) begin
        issue(CMD_CLEAR, pick_id(), pick_lat(s), pick_lon(s));
        lat_seen.delete();
        lon_seen.delete();
        sent++;
      end
      while (n_pts + n_q != 0) begin
        k = $urandom_range(0, n_pts + n_q - 1);
        if ($urandom_range(0, 19) == 0) begin
          issue(CMD_UNUSED, pick_id(), pick_lat(SPREAD_RAW), pick_lon(SPREAD_RAW));
        end else if (k < n_pts) begin
          la = pick_lat(s);
          lo = pick_lon(s);
          issue(CMD_LOAD, pick_id(), la, lo);
          lat_seen.push_back(la);
          lon_seen.push_back(lo);
          n_pts--;
          sent++;
        end else begin
          if (lat_seen.size() != 0 && $urandom_range(0, 1) == 1) begin
            // land close to a stored point
            j  = $urandom_range(0, lat_seen.size() - 1);
            la = lat_seen[j] + LAT_W'(int'($urandom_range(0, 4)) - 2);
            lo = lon_seen[j] + LON_W'(int'($urandom_range(0, 4)) - 2);
          end else begin
            la = pick_lat(s);
            lo = pick_lon(s);
          end
          issue(CMD_QUERY, pick_id(), la, lo);
          n_q--;
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    stall_taken    = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned still;
    still = 0;
    while (still < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) still = 0;
      else still++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.cmd       = CMD_CLEAR;
    in_chan.entry_id  = '0;
    in_chan.coord_lat = '0;
    in_chan.coord_lon = '0;
    stall_req         = 1'b0;
    quiet             = 1'b0;
    gap_pct           = 25;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused command, extremes, ties and duplicate ids
    issue(CMD_QUERY, '0, '0, '0);
    issue(CMD_UNUSED, ID_TOP, LAT_BOT, LON_TOP);
    issue(CMD_QUERY, '0, LAT_TOP, LON_BOT);
    issue(CMD_LOAD, ID_TOP, LAT_W'(9000000), LON_W'(18000000));
    issue(CMD_LOAD, '0, LAT_W'(-9000000), LON_W'(-18000000));
    issue(CMD_LOAD, ID_W'(5), '0, '0);
    issue(CMD_LOAD, ID_W'(6), '0, '0);
    issue(CMD_LOAD, ID_W'(9), LAT_TOP, LON_BOT);
    issue(CMD_LOAD, ID_W'(10), LAT_BOT, LON_TOP);
    issue(CMD_QUERY, ID_TOP, '0, '0);
    issue(CMD_QUERY, '0, LAT_W'(9000000), LON_W'(18000000));
    issue(CMD_QUERY, '0, LAT_W'(-9000000), LON_W'(-18000000));
    issue(CMD_QUERY, '0, LAT_TOP, LON_BOT);
    issue(CMD_QUERY, '0, LAT_BOT, LON_TOP);
    issue(CMD_CLEAR, ID_TOP, LAT_TOP, LON_TOP);
    issue(CMD_LOAD, ID_W'(100), LAT_W'(3), '0);
    issue(CMD_LOAD, ID_W'(101), '0, LON_W'(-3));
    issue(CMD_LOAD, ID_W'(100), LAT_W'(-1), LON_W'(2));
    issue(CMD_QUERY, '0, '0, '0);
    issue(CMD_QUERY, '0, LAT_W'(1), LON_W'(-1));
    issue(CMD_UNUSED, '0, '0, '0);
    issue(CMD_QUERY, '0, LAT_W'(-1), LON_W'(2));
    issue(CMD_CLEAR, '0, '0, '0);
    issue(CMD_QUERY, '0, '0, '0);
    wait_for_answers();

    gap_pct = 25;
    run_random_sets(270);
    wait_for_answers();

    // receiver holds off while items keep coming, so the input backs up
    stall_req = 1'b1;
    while (!stall_taken) @(posedge clk);
    gap_pct = 0;
    run_random_sets(40);
    wait_for_answers();

    gap_pct = 25;
    run_random_sets(160);
    wait_for_answers();

    quiet   = 1'b1;
    gap_pct = 0;
    run_random_sets(80);
    wait_for_answers();
    repeat (16) @(posedge clk);

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
